// File: src/yuy2_rgb_pixel_converter_assert.svh
// Assertion macros for the YUY2/RGB pixel converter
`ifndef YUY2_RGB_PIXEL_CONVERTER_ASSERT_SVH
`define YUY2_RGB_PIXEL_CONVERTER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off during reset
`define Y2R_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("y2r assertion failed");
// next-cycle implication
`define Y2R_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("y2r assertion failed");
`else
`define Y2R_ASSERT_IMPLY(label, ante, cons)
`define Y2R_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: src/y2r_pkg.sv
// Shared types and constants for the YUY2/RGB pixel converter
package y2r_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PIXEL_W = 24;
  localparam int unsigned COUNT_W = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // chroma offset term after Q1.14 truncation, fits -256..255
  localparam int unsigned OFS_W = 9;
  // product and sum width for the chroma multiplies
  localparam int unsigned PROD_W = 26;
  localparam int unsigned FRAC_W = 14;

  // BT.601 coefficients, unsigned Q1.14
  localparam logic [14:0] K_R  = 15'd22970;
  localparam logic [14:0] K_GU = 15'd5636;
  localparam logic [14:0] K_GV = 15'd11698;
  localparam logic [14:0] K_B  = 15'd29032;
  localparam logic [BYTE_W-1:0] CHROMA_OFS = 8'd128;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_FORMAT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_FORMAT = 2'd1;

  localparam logic IN_FMT_RGB24  = 1'b0;
  localparam logic IN_FMT_YUY2   = 1'b1;
  localparam logic OUT_FMT_RGB565 = 1'b0;
  localparam logic OUT_FMT_BGR24  = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_ONE = 2'd1;
  localparam logic [COUNT_W-1:0] COUNT_TWO = 2'd2;

  typedef logic signed [OFS_W-1:0] ofs_t;

  // per-channel additive terms shared by both pixels of a pair
  typedef struct packed {
    ofs_t r_ofs;
    ofs_t g_ofs;  // already negated
    ofs_t b_ofs;
  } chroma_t;

endpackage

// File: src/y2r_pix_in_if.sv
// Input item channel: one YUY2 pair or one RGB24 pixel
interface y2r_pix_in_if;
  logic                          valid;
  logic                          ready;
  logic [y2r_pkg::BYTE_W-1:0]    first_byte;
  logic [y2r_pkg::BYTE_W-1:0]    second_byte;
  logic [y2r_pkg::BYTE_W-1:0]    third_byte;
  logic [y2r_pkg::BYTE_W-1:0]    fourth_byte;
  logic                          frame_end;

  modport source (output valid, first_byte, second_byte, third_byte, fourth_byte,
                  frame_end, input ready);
  modport sink   (input valid, first_byte, second_byte, third_byte, fourth_byte,
                  frame_end, output ready);
endinterface

// File: src/y2r_pix_out_if.sv
// Result item channel: one or two packed pixels
interface y2r_pix_out_if;
  logic                          valid;
  logic                          ready;
  logic [y2r_pkg::PIXEL_W-1:0]   pixel_first;
  logic [y2r_pkg::PIXEL_W-1:0]   pixel_second;
  logic [y2r_pkg::COUNT_W-1:0]   pixel_count;
  logic                          frame_end_out;

  modport source (output valid, pixel_first, pixel_second, pixel_count, frame_end_out,
                  input ready);
  modport sink   (input valid, pixel_first, pixel_second, pixel_count, frame_end_out,
                  output ready);
endinterface

// File: src/y2r_cfg_if.sv
// Configuration write channel
interface y2r_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [y2r_pkg::CFG_IDX_W-1:0]    index;
  logic [y2r_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/yuy2_rgb_pixel_converter.sv
// Top level: YUY2 pair or RGB24 pixel in, RGB565 or B,G,R pixels out
// Two register stages, input reg then result reg, lie between input acceptance and result valid.
// Throughput: one item per cycle; both stages advance while the result side drains.
// Chroma multiply, clamp and pack sit in one pass between the two registers.
// Reset (rst_n low, synchronous) empties both stages, input_format -> YUY2,
// output_format -> RGB565. Config writes are always ready.
`include "yuy2_rgb_pixel_converter_assert.svh"

module yuy2_rgb_pixel_converter (
  input  logic               clk,
  input  logic               rst_n,
  y2r_pix_in_if.sink         in_ch,
  y2r_pix_out_if.source      out_ch,
  y2r_cfg_if.sink            cfg_ch
);

  localparam int unsigned BW = y2r_pkg::BYTE_W;
  localparam int unsigned PW = y2r_pkg::PIXEL_W;

  // configuration
  logic in_fmt_r, in_fmt_nxt;
  logic out_fmt_r, out_fmt_nxt;

  // input stage
  logic          s1_valid_r, s1_valid_nxt;
  logic [BW-1:0] b0_r, b1_r, b2_r, b3_r;
  logic          fe_r;

  // result stage
  logic                          out_valid_r, out_valid_nxt;
  logic [PW-1:0]                 pix0_r, pix1_r;
  logic [y2r_pkg::COUNT_W-1:0]   count_r;
  logic                          fe_out_r;

  logic in_acc, out_acc, cfg_acc, s2_ready, s2_load, yuv_mode;

  y2r_pkg::chroma_t chroma_yuv;
  y2r_pkg::chroma_t chroma_sel;
  logic [BW-1:0]    p0_r_base, p0_g_base, p0_b_base;
  logic [PW-1:0]    pix0_comb, pix1_comb;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    in_fmt_nxt  = in_fmt_r;
    out_fmt_nxt = out_fmt_r;
    if (cfg_acc) begin
      unique case (cfg_ch.index)
        y2r_pkg::REG_INPUT_FORMAT:  in_fmt_nxt  = cfg_ch.data[0];
        y2r_pkg::REG_OUTPUT_FORMAT: out_fmt_nxt = cfg_ch.data[0];
        default: ;  // unknown register, write dropped
      endcase
    end
  end

  // handshake
  assign s2_ready     = !out_valid_r || out_ch.ready;
  assign s2_load      = s1_valid_r && s2_ready;
  assign in_ch.ready  = !s1_valid_r || s2_ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_acc      = out_valid_r && out_ch.ready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (s2_load ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s2_load ? 1'b1 : (out_acc ? 1'b0 : out_valid_r);

  // datapath
  assign yuv_mode = (in_fmt_r == y2r_pkg::IN_FMT_YUY2);

  y2r_chroma u_chroma (
    .u_byte (b1_r),
    .v_byte (b3_r),
    .chroma (chroma_yuv)
  );

  // RGB24 goes through the same clamp/pack with zero chroma terms
  assign chroma_sel = yuv_mode ? chroma_yuv : '0;
  assign p0_r_base  = b0_r;
  assign p0_g_base  = yuv_mode ? b0_r : b1_r;
  assign p0_b_base  = yuv_mode ? b0_r : b2_r;

  y2r_pixel u_pixel0 (
    .base_r  (p0_r_base),
    .base_g  (p0_g_base),
    .base_b  (p0_b_base),
    .chroma  (chroma_sel),
    .out_fmt (out_fmt_r),
    .pixel   (pix0_comb)
  );

  y2r_pixel u_pixel1 (
    .base_r  (b2_r),
    .base_g  (b2_r),
    .base_b  (b2_r),
    .chroma  (chroma_yuv),
    .out_fmt (out_fmt_r),
    .pixel   (pix1_comb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_fmt_r    <= y2r_pkg::IN_FMT_YUY2;
      out_fmt_r   <= y2r_pkg::OUT_FMT_RGB565;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_fmt_r    <= in_fmt_nxt;
      out_fmt_r   <= out_fmt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b0_r <= in_ch.first_byte;
      b1_r <= in_ch.second_byte;
      b2_r <= in_ch.third_byte;
      b3_r <= in_ch.fourth_byte;
      fe_r <= in_ch.frame_end;
    end
    if (s2_load) begin
      pix0_r   <= pix0_comb;
      pix1_r   <= yuv_mode ? pix1_comb : '0;
      count_r  <= yuv_mode ? y2r_pkg::COUNT_TWO : y2r_pkg::COUNT_ONE;
      fe_out_r <= fe_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_first   = pix0_r;
  assign out_ch.pixel_second  = pix1_r;
  assign out_ch.pixel_count   = count_r;
  assign out_ch.frame_end_out = fe_out_r;

  `Y2R_ASSERT_NEXT(a_stage_advance, s2_load, out_valid_r)
  `Y2R_ASSERT_IMPLY(a_count_legal, out_valid_r, count_r == y2r_pkg::COUNT_ONE || count_r == y2r_pkg::COUNT_TWO)
  `Y2R_ASSERT_IMPLY(a_single_zero, out_valid_r && count_r == y2r_pkg::COUNT_ONE, pix1_r == '0)
  `Y2R_ASSERT_IMPLY(a_565_upper_zero, out_valid_r && out_fmt_r == y2r_pkg::OUT_FMT_RGB565, pix0_r[23:16] == 8'h00 && pix1_r[23:16] == 8'h00)
  `Y2R_ASSERT_NEXT(a_full_holds, s1_valid_r && !s2_ready, s1_valid_r && $stable(b0_r))

endmodule

// File: src/y2r_chroma.sv
// BT.601 chroma terms from U and V, Q1.14 coefficient products truncated toward zero
module y2r_chroma (
  input  logic [y2r_pkg::BYTE_W-1:0] u_byte,
  input  logic [y2r_pkg::BYTE_W-1:0] v_byte,
  output y2r_pkg::chroma_t           chroma
);

  localparam int unsigned PW = y2r_pkg::PROD_W;
  localparam int unsigned FW = y2r_pkg::FRAC_W;
  localparam int unsigned OW = y2r_pkg::OFS_W;

  localparam logic signed [PW-1:0] KR_S  = PW'(y2r_pkg::K_R);
  localparam logic signed [PW-1:0] KGU_S = PW'(y2r_pkg::K_GU);
  localparam logic signed [PW-1:0] KGV_S = PW'(y2r_pkg::K_GV);
  localparam logic signed [PW-1:0] KB_S  = PW'(y2r_pkg::K_B);

  logic signed [y2r_pkg::BYTE_W:0] u_s;
  logic signed [y2r_pkg::BYTE_W:0] v_s;
  logic signed [PW-1:0] u_ext;
  logic signed [PW-1:0] v_ext;
  logic signed [PW-1:0] r_prod;
  logic signed [PW-1:0] g_prod;
  logic signed [PW-1:0] b_prod;
  logic signed [OW-1:0] g_term;

  // divide by 2^14 rounding toward zero: bias negatives by 2^14-1 first
  function automatic logic signed [OW-1:0] trunc_q14(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] biased;
    biased = p + {{(PW-FW){1'b0}}, {FW{p[PW-1]}}};
    return biased[FW+OW-1:FW];
  endfunction

  assign u_s = $signed({1'b0, u_byte}) - $signed({1'b0, y2r_pkg::CHROMA_OFS});
  assign v_s = $signed({1'b0, v_byte}) - $signed({1'b0, y2r_pkg::CHROMA_OFS});
  assign u_ext = PW'(u_s);
  assign v_ext = PW'(v_s);

  assign r_prod = KR_S * v_ext;
  assign g_prod = KGU_S * u_ext + KGV_S * v_ext;  // summed before truncation
  assign b_prod = KB_S * u_ext;

  assign g_term = trunc_q14(g_prod);

  assign chroma.r_ofs = trunc_q14(r_prod);
  assign chroma.g_ofs = -g_term;
  assign chroma.b_ofs = trunc_q14(b_prod);

endmodule

// File: src/y2r_pixel.sv
// One pixel: add chroma terms, clamp to 0..255, pack as RGB565 or B,G,R bytes
module y2r_pixel (
  input  logic [y2r_pkg::BYTE_W-1:0]  base_r,
  input  logic [y2r_pkg::BYTE_W-1:0]  base_g,
  input  logic [y2r_pkg::BYTE_W-1:0]  base_b,
  input  y2r_pkg::chroma_t            chroma,
  input  logic                        out_fmt,
  output logic [y2r_pkg::PIXEL_W-1:0] pixel
);

  localparam int unsigned BW = y2r_pkg::BYTE_W;
  localparam int unsigned OW = y2r_pkg::OFS_W;
  localparam int unsigned SW = BW + 3;

  logic [BW-1:0] r8;
  logic [BW-1:0] g8;
  logic [BW-1:0] b8;

  function automatic logic [BW-1:0] add_clamp(input logic [BW-1:0] base,
                                              input y2r_pkg::ofs_t ofs);
    logic signed [SW-1:0] s;
    s = $signed({3'b000, base}) + $signed({{(SW-OW){ofs[OW-1]}}, ofs});
    if (s[SW-1])
      return '0;
    else if (s[SW-2:BW] != '0)
      return '1;
    else
      return s[BW-1:0];
  endfunction

  assign r8 = add_clamp(base_r, chroma.r_ofs);
  assign g8 = add_clamp(base_g, chroma.g_ofs);
  assign b8 = add_clamp(base_b, chroma.b_ofs);

  always_comb begin
    if (out_fmt == y2r_pkg::OUT_FMT_BGR24)
      pixel = {r8, g8, b8};
    else
      pixel = {8'h00, r8[7:3], g8[7:2], b8[7:3]};
  end

endmodule

// File: verif/tb.sv
// Self-checking testbench for the YUY2/RGB24 to RGB565/BGR24 pixel converter
module tb;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int RANDOM_PHASES   = 8;
  localparam int Q_ONE = 1 << y2r_pkg::FRAC_W;
  localparam logic [y2r_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [y2r_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [y2r_pkg::BYTE_W-1:0] first_byte;
    logic [y2r_pkg::BYTE_W-1:0] second_byte;
    logic [y2r_pkg::BYTE_W-1:0] third_byte;
    logic [y2r_pkg::BYTE_W-1:0] fourth_byte;
    logic                       frame_end;
  } pixel_item_t;

  typedef struct packed {
    logic [y2r_pkg::PIXEL_W-1:0] pixel_first;
    logic [y2r_pkg::PIXEL_W-1:0] pixel_second;
    logic [y2r_pkg::COUNT_W-1:0] pixel_count;
    logic                        frame_end_out;
  } pixel_word_t;

  logic clk = 1'b0;
  logic rst_n;

  y2r_pix_in_if  in_ch ();
  y2r_pix_out_if out_ch ();
  y2r_cfg_if     cfg_ch ();

  yuy2_rgb_pixel_converter u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pixel_item_t items_to_send[$];
  pixel_word_t pixels_due[$];
  pixel_item_t next_item;
  logic cur_in_fmt;
  logic cur_out_fmt;
  logic no_idle;
  logic in_fire;
  logic out_fire;
  int   in_gap;
  int   out_stall;
  int   items_queued;
  int   items_accepted;
  int   mismatches;
  int   stall_cycles;

  function automatic logic [y2r_pkg::BYTE_W-1:0] sat_byte(int x);
    if (x < 0) return '0;
    if (x > 255) return 8'hFF;
    return x[y2r_pkg::BYTE_W-1:0];
  endfunction

  function automatic logic [y2r_pkg::PIXEL_W-1:0] pack_pixel(logic [7:0] r, logic [7:0] g,
                                                             logic [7:0] b, logic out_fmt);
    if (out_fmt == y2r_pkg::OUT_FMT_BGR24) return {r, g, b};
    return {8'h00, r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [y2r_pkg::PIXEL_W-1:0] yuv_to_pixel(int y, int u, int v,
                                                               logic out_fmt);
    int r, g, b;
    r = y + (int'(y2r_pkg::K_R) * v) / Q_ONE;
    // both green products summed before the divide by Q_ONE
    g = y - (int'(y2r_pkg::K_GU) * u + int'(y2r_pkg::K_GV) * v) / Q_ONE;
    b = y + (int'(y2r_pkg::K_B) * u) / Q_ONE;
    return pack_pixel(sat_byte(r), sat_byte(g), sat_byte(b), out_fmt);
  endfunction

  function automatic pixel_word_t convert_item(pixel_item_t it, logic in_fmt, logic out_fmt);
    pixel_word_t w;
    int u, v;
    u = int'(it.second_byte) - int'(y2r_pkg::CHROMA_OFS);
    v = int'(it.fourth_byte) - int'(y2r_pkg::CHROMA_OFS);
    if (in_fmt == y2r_pkg::IN_FMT_YUY2) begin
      w.pixel_first  = yuv_to_pixel(int'(it.first_byte), u, v, out_fmt);
      w.pixel_second = yuv_to_pixel(int'(it.third_byte), u, v, out_fmt);
      w.pixel_count  = y2r_pkg::COUNT_TWO;
    end else begin
      w.pixel_first  = pack_pixel(it.first_byte, it.second_byte, it.third_byte, out_fmt);
      w.pixel_second = '0;
      w.pixel_count  = y2r_pkg::COUNT_ONE;
    end
    w.frame_end_out = it.frame_end;
    return w;
  endfunction

  function automatic logic [y2r_pkg::BYTE_W-1:0] rand_byte();
    // lean on the extremes now and then to hit the clamps
    unique case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_item(pixel_item_t it);
    items_to_send.push_back(it);
    items_queued++;
  endtask

  task automatic queue_directed();
    queue_item('{8'h00, 8'h00, 8'h00, 8'h00, 1'b0});
    queue_item('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1});
    queue_item('{8'h00, 8'h80, 8'hFF, 8'h80, 1'b0});
    queue_item('{8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0});
    queue_item('{8'h00, 8'hFF, 8'hFF, 8'h00, 1'b1});
    queue_item('{8'hF8, 8'hFC, 8'h07, 8'h5A, 1'b0});
  endtask

  task automatic write_reg(logic [y2r_pkg::CFG_IDX_W-1:0] idx,
                           logic [y2r_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // upper data bits are noise: only bit 0 should count
  task automatic set_formats(logic in_fmt, logic out_fmt);
    write_reg(y2r_pkg::REG_INPUT_FORMAT, {7'($urandom), in_fmt});
    write_reg(y2r_pkg::REG_OUTPUT_FORMAT, {7'($urandom), out_fmt});
    write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_3 : REG_SPARE_2, 8'($urandom));
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (items_accepted != items_queued || pixels_due.size() != 0);
  endtask

  // input side: one item per handshake, random gap before the next (none while no_idle is set)
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      in_fire = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (items_to_send.size() > 0) begin
        next_item = items_to_send.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.first_byte  <= next_item.first_byte;
        in_ch.second_byte <= next_item.second_byte;
        in_ch.third_byte  <= next_item.third_byte;
        in_ch.fourth_byte <= next_item.fourth_byte;
        in_ch.frame_end   <= next_item.frame_end;
        in_gap = no_idle ? 0 : $urandom_range(0, 5);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side: random stall after each item taken (none while no_idle is set)
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_fire) begin
        out_fire  = 1'b0;
        out_stall = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pixel_word_t got, want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        in_fire = 1'b1;
        items_accepted++;
        pixels_due.push_back(convert_item('{in_ch.first_byte, in_ch.second_byte,
                                            in_ch.third_byte, in_ch.fourth_byte,
                                            in_ch.frame_end}, cur_in_fmt, cur_out_fmt));
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          y2r_pkg::REG_INPUT_FORMAT:  cur_in_fmt  = cfg_ch.data[0];
          y2r_pkg::REG_OUTPUT_FORMAT: cur_out_fmt = cfg_ch.data[0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        out_fire = 1'b1;
        got = '{out_ch.pixel_first, out_ch.pixel_second, out_ch.pixel_count,
                out_ch.frame_end_out};
        if (pixels_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: first %h second %h count %0d fe %b",
                     got.pixel_first, got.pixel_second, got.pixel_count, got.frame_end_out);
        end else begin
          want = pixels_due.pop_front();
          if (got.pixel_first !== want.pixel_first || got.pixel_second !== want.pixel_second
              || got.pixel_count !== want.pixel_count
              || got.frame_end_out !== want.frame_end_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h %h %0d %b, got %h %h %0d %b",
                       want.pixel_first, want.pixel_second, want.pixel_count,
                       want.frame_end_out, got.pixel_first, got.pixel_second,
                       got.pixel_count, got.frame_end_out);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic in_fmt, out_fmt;
    pixel_item_t it;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.first_byte = '0;
    in_ch.second_byte = '0;
    in_ch.third_byte = '0;
    in_ch.fourth_byte = '0;
    in_ch.frame_end = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    cur_in_fmt = y2r_pkg::IN_FMT_YUY2;
    cur_out_fmt = y2r_pkg::OUT_FMT_RGB565;
    no_idle = 1'b0;
    in_fire = 1'b0;
    out_fire = 1'b0;
    in_gap = 0;
    out_stall = 0;
    items_queued = 0;
    items_accepted = 0;
    mismatches = 0;
    stall_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed items under reset settings, then under every other setting
    queue_directed();
    wait_drained();
    set_formats(y2r_pkg::IN_FMT_RGB24, y2r_pkg::OUT_FMT_RGB565);
    queue_directed();
    wait_drained();
    set_formats(y2r_pkg::IN_FMT_RGB24, y2r_pkg::OUT_FMT_BGR24);
    queue_directed();
    wait_drained();
    set_formats(y2r_pkg::IN_FMT_YUY2, y2r_pkg::OUT_FMT_BGR24);
    queue_directed();
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < 4) begin
        in_fmt  = ph[1];
        out_fmt = ph[0];
      end else begin
        in_fmt  = 1'($urandom);
        out_fmt = 1'($urandom);
      end
      no_idle = (ph == 2 || ph == 5);
      set_formats(in_fmt, out_fmt);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it.first_byte  = rand_byte();
        it.second_byte = rand_byte();
        it.third_byte  = rand_byte();
        it.fourth_byte = rand_byte();
        it.frame_end   = ($urandom_range(0, 15) == 0);
        queue_item(it);
      end
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pixels_due.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/y2r_pkg.sv
src/y2r_pix_in_if.sv
src/y2r_pix_out_if.sv
src/y2r_cfg_if.sv
src/y2r_chroma.sv
src/y2r_pixel.sv
src/yuy2_rgb_pixel_converter.sv
verif/tb.sv
